### rtl/sprite_blit_clip_flip_colorkey_top_assert.svh
// assertion macros used by the blitter pixel stage (sbcf_px)
`ifndef SPRITE_BLIT_CLIP_FLIP_COLORKEY_TOP_ASSERT_SVH
`define SPRITE_BLIT_CLIP_FLIP_COLORKEY_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SBCF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbcf assertion failed");

// next-cycle implication, disabled in reset
`define SBCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbcf assertion failed");

`endif

### rtl/sbcf_pkg.sv
package sbcf_pkg;

  localparam int SPR_W  = 8;
  localparam int SCR_W  = 10;
  localparam int POS_W  = 10;
  localparam int PIX_W  = 16;
  localparam int ADDR_W = 18;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int COORD_W = 12;

  localparam logic [PIX_W-1:0] RG_MASK   = 16'hF800 | 16'h07E0;
  localparam logic [PIX_W-1:0] BLUE_MASK = 16'h003E;
  localparam logic [PIX_W-1:0] ALPHA_MASK = 16'h0001;

  localparam logic [SPR_W-1:0] RST_SPRITE_COLS = 8'd1;
  localparam logic [SPR_W-1:0] RST_SPRITE_ROWS = 8'd1;
  localparam logic [SCR_W-1:0] RST_SCREEN_COLS = 10'd320;
  localparam logic [SCR_W-1:0] RST_SCREEN_ROWS = 10'd240;

  typedef enum logic [2:0] {
    REG_SPRITE_COLS = 3'd0,
    REG_SPRITE_ROWS = 3'd1,
    REG_POS_X       = 3'd2,
    REG_POS_Y       = 3'd3,
    REG_SCREEN_COLS = 3'd4,
    REG_SCREEN_ROWS = 3'd5,
    REG_MIRROR_MODE = 3'd6,
    REG_SHOWN       = 3'd7
  } reg_idx_t;

  // effective settings, sizes already clamped
  typedef struct packed {
    logic [SPR_W-1:0]        cols;
    logic [SPR_W-1:0]        rows;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [SCR_W-1:0]        scols;
    logic [SCR_W-1:0]        srows;
    logic                    mirror_h;
    logic                    mirror_v;
    logic                    shown;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [SPR_W-1:0] col;
    logic [SPR_W-1:0] row;
    logic             done;
  } stage_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pix;
    logic              done;
  } res_t;

endpackage

### rtl/sbcf_cfg.sv
module sbcf_cfg #(
  parameter int MAX_SPRITE = 128,
  parameter int MAX_SCREEN = 512
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sbcf_pkg::PADDR_W-1:0]      paddr,
  input  logic [sbcf_pkg::PDATA_W-1:0]      pwdata,
  output logic [sbcf_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready,
  output sbcf_pkg::cfg_t                    cfg,
  output logic                              restart
);

  localparam logic [12:0] MAX_SPR_L = 13'(MAX_SPRITE);
  localparam logic [12:0] MAX_SCR_L = 13'(MAX_SCREEN);

  logic [sbcf_pkg::SPR_W-1:0]        sprite_cols_r;
  logic [sbcf_pkg::SPR_W-1:0]        sprite_rows_r;
  logic signed [sbcf_pkg::POS_W-1:0] pos_x_r;
  logic signed [sbcf_pkg::POS_W-1:0] pos_y_r;
  logic [sbcf_pkg::SCR_W-1:0]        screen_cols_r;
  logic [sbcf_pkg::SCR_W-1:0]        screen_rows_r;
  logic [1:0]                        mirror_mode_r;
  logic                              shown_r;
  logic                              wr_en;
  sbcf_pkg::reg_idx_t                idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = sbcf_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sprite_cols_r <= sbcf_pkg::RST_SPRITE_COLS;
      sprite_rows_r <= sbcf_pkg::RST_SPRITE_ROWS;
      pos_x_r       <= '0;
      pos_y_r       <= '0;
      screen_cols_r <= sbcf_pkg::RST_SCREEN_COLS;
      screen_rows_r <= sbcf_pkg::RST_SCREEN_ROWS;
      mirror_mode_r <= '0;
      shown_r       <= 1'b1;
    end else if (wr_en) begin
      unique case (idx)
        sbcf_pkg::REG_SPRITE_COLS: sprite_cols_r <= pwdata[7:0];
        sbcf_pkg::REG_SPRITE_ROWS: sprite_rows_r <= pwdata[7:0];
        sbcf_pkg::REG_POS_X:       pos_x_r       <= pwdata[9:0];
        sbcf_pkg::REG_POS_Y:       pos_y_r       <= pwdata[9:0];
        sbcf_pkg::REG_SCREEN_COLS: screen_cols_r <= pwdata[9:0];
        sbcf_pkg::REG_SCREEN_ROWS: screen_rows_r <= pwdata[9:0];
        sbcf_pkg::REG_MIRROR_MODE: mirror_mode_r <= pwdata[1:0];
        sbcf_pkg::REG_SHOWN:       shown_r       <= pwdata[0];
        default: ;
      endcase
    end
  end

  // size or mirror rewrite restarts the sprite
  assign restart = wr_en && (idx == sbcf_pkg::REG_SPRITE_COLS ||
                             idx == sbcf_pkg::REG_SPRITE_ROWS ||
                             idx == sbcf_pkg::REG_MIRROR_MODE);

  always_comb begin
    unique case (idx)
      sbcf_pkg::REG_SPRITE_COLS: prdata = 32'(sprite_cols_r);
      sbcf_pkg::REG_SPRITE_ROWS: prdata = 32'(sprite_rows_r);
      sbcf_pkg::REG_POS_X:       prdata = 32'(pos_x_r);
      sbcf_pkg::REG_POS_Y:       prdata = 32'(pos_y_r);
      sbcf_pkg::REG_SCREEN_COLS: prdata = 32'(screen_cols_r);
      sbcf_pkg::REG_SCREEN_ROWS: prdata = 32'(screen_rows_r);
      sbcf_pkg::REG_MIRROR_MODE: prdata = 32'(mirror_mode_r);
      sbcf_pkg::REG_SHOWN:       prdata = 32'(shown_r);
      default:                   prdata = '0;
    endcase
  end

  // clamping of sizes
  always_comb begin
    if (sprite_cols_r == '0) begin
      cfg.cols = 8'd1;
    end else if (13'(sprite_cols_r) > MAX_SPR_L) begin
      cfg.cols = 8'(MAX_SPRITE);
    end else begin
      cfg.cols = sprite_cols_r;
    end
    if (sprite_rows_r == '0) begin
      cfg.rows = 8'd1;
    end else if (13'(sprite_rows_r) > MAX_SPR_L) begin
      cfg.rows = 8'(MAX_SPRITE);
    end else begin
      cfg.rows = sprite_rows_r;
    end
    cfg.scols = (13'(screen_cols_r) > MAX_SCR_L) ? 10'(MAX_SCREEN) : screen_cols_r;
    cfg.srows = (13'(screen_rows_r) > MAX_SCR_L) ? 10'(MAX_SCREEN) : screen_rows_r;
    cfg.pos_x    = pos_x_r;
    cfg.pos_y    = pos_y_r;
    cfg.mirror_h = mirror_mode_r[0];
    cfg.mirror_v = mirror_mode_r[1];
    cfg.shown    = shown_r;
  end

endmodule

### rtl/sbcf_in.sv
module sbcf_in #(
  parameter int MAX_SPRITE = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sbcf_pkg::PIX_W-1:0]    in_src_pixel,
  input  sbcf_pkg::cfg_t                cfg,
  input  logic                          restart,
  output logic                          s1_valid,
  input  logic                          s1_ready,
  output sbcf_pkg::stage_t              s1
);

  localparam int CW_RAW = $clog2(MAX_SPRITE);
  localparam int CNT_W  = (CW_RAW < 1) ? 1 : ((CW_RAW > 8) ? 8 : CW_RAW);

  logic [CNT_W-1:0]          col_r, col_nxt;
  logic [CNT_W-1:0]          row_r, row_nxt;
  logic                      s1_v_r;
  sbcf_pkg::stage_t          s1_r;
  logic [sbcf_pkg::SPR_W-1:0] c, r;
  logic [sbcf_pkg::SPR_W:0]  c_inc, r_inc;
  logic                      last_col, done;
  logic                      accept;

  assign in_ready = !s1_v_r || s1_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    c = (8'(col_r) < cfg.cols) ? 8'(col_r) : cfg.cols - 8'd1;
    r = (8'(row_r) < cfg.rows) ? 8'(row_r) : cfg.rows - 8'd1;
    c_inc = 9'(c) + 9'd1;
    r_inc = 9'(r) + 9'd1;
    last_col = c_inc >= 9'(cfg.cols);
    done     = last_col && (r_inc >= 9'(cfg.rows));
    if (last_col) begin
      col_nxt = '0;
      row_nxt = done ? '0 : CNT_W'(r_inc);
    end else begin
      col_nxt = CNT_W'(c_inc);
      row_nxt = CNT_W'(r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      if (restart) begin
        col_r <= '0;
        row_r <= '0;
      end else if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.pix  <= in_src_pixel;
      s1_r.col  <= c;
      s1_r.row  <= r;
      s1_r.done <= done;
    end
  end

  assign s1_valid = s1_v_r;
  assign s1       = s1_r;

endmodule

### rtl/sbcf_px.sv
`include "sprite_blit_clip_flip_colorkey_top_assert.svh"

module sbcf_px (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               s1_valid,
  output logic               s1_ready,
  input  sbcf_pkg::stage_t   s1,
  input  sbcf_pkg::cfg_t     cfg,
  output logic               out_valid,
  input  logic               out_ready,
  output sbcf_pkg::res_t     res
);

  logic                                 out_v_r;
  sbcf_pkg::res_t                       res_r, res_nxt;
  logic [sbcf_pkg::SPR_W-1:0]           dc, dr;
  logic signed [sbcf_pkg::COORD_W-1:0]  x, y;
  logic                                 on_screen, we;
  logic [2*sbcf_pkg::SCR_W-1:0]         row_base;
  logic [2*sbcf_pkg::SCR_W:0]           addr_full;

  assign s1_ready = !out_v_r || out_ready;

  always_comb begin
    dc = cfg.mirror_h ? (cfg.cols - 8'd1 - s1.col) : s1.col;
    dr = cfg.mirror_v ? (cfg.rows - 8'd1 - s1.row) : s1.row;
    x  = $signed({4'b0, dc}) + 12'(cfg.pos_x);
    y  = $signed({4'b0, dr}) + 12'(cfg.pos_y);
    on_screen = !x[sbcf_pkg::COORD_W-1] && !y[sbcf_pkg::COORD_W-1] &&
                (x < $signed({2'b0, cfg.scols})) && (y < $signed({2'b0, cfg.srows}));
    we = on_screen && cfg.shown && ((s1.pix & sbcf_pkg::ALPHA_MASK) != '0);
    row_base  = y[sbcf_pkg::SCR_W-1:0] * cfg.scols;
    addr_full = 21'(row_base) + 21'(x[sbcf_pkg::SCR_W-1:0]);
    res_nxt.we   = we;
    res_nxt.addr = we ? addr_full[sbcf_pkg::ADDR_W-1:0] : '0;
    res_nxt.pix  = we ? ((s1.pix & sbcf_pkg::RG_MASK) | ((s1.pix & sbcf_pkg::BLUE_MASK) >> 1))
                      : '0;
    res_nxt.done = s1.done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_ready) begin
      out_v_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_ready) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign res       = res_r;

  `SBCF_ASSERT_NOW(a_no_write_zero, clk, rst_n, out_v_r && !res_r.we,
                   res_r.addr == '0 && res_r.pix == '0)
  `SBCF_ASSERT_NEXT(a_stage_moves, clk, rst_n, s1_valid && s1_ready, out_v_r)
  `SBCF_ASSERT_NEXT(a_result_kept, clk, rst_n, out_v_r && !out_ready, out_v_r)

endmodule

### rtl/sprite_blit_clip_flip_colorkey_top.sv
// sprite blitter with colour key, clipping and mirroring
// input channel: in_valid/in_ready carry one sprite pixel per transaction in
// raster order; bit 0 of in_src_pixel marks the pixel opaque
// result channel: out_valid/out_ready carry one frame buffer write per input
// transaction: write enable, linear address, pixel without alpha bit, and an
// end-of-sprite mark on the last pixel
// settings: APB-style register port; the user must write it only while no pixel
// is in flight, which the block does not enforce; rewriting sprite size or
// mirror mode restarts the sprite at its first pixel; path: input register,
// then result register after mirror, offset, clip and one 10x10 multiply
// throughput: one pixel per clock if out_ready is high; two-register pipeline
// receiver stall: the result register holds, the input register fills, then
// in_ready drops; nothing is lost or repeated
// reset: synchronous active-low rst_n empties the pipeline, clears the sprite
// counters and loads the register defaults (1x1 sprite at 0,0, 320x240 screen,
// no mirroring, shown)
module sprite_blit_clip_flip_colorkey_top #(
  parameter int MAX_SPRITE = 128,
  parameter int MAX_SCREEN = 512
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sbcf_pkg::PIX_W-1:0]      in_src_pixel,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_write_enable,
  output logic [sbcf_pkg::ADDR_W-1:0]     out_fb_address,
  output logic [sbcf_pkg::PIX_W-1:0]      out_pixel,
  output logic                            out_sprite_done,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sbcf_pkg::PADDR_W-1:0]    paddr,
  input  logic [sbcf_pkg::PDATA_W-1:0]    pwdata,
  output logic [sbcf_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);

  sbcf_pkg::cfg_t   cfg;
  sbcf_pkg::stage_t s1;
  sbcf_pkg::res_t   res;
  logic             restart;
  logic             s1_valid, s1_ready;

  sbcf_cfg #(
    .MAX_SPRITE (MAX_SPRITE),
    .MAX_SCREEN (MAX_SCREEN)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .restart (restart)
  );

  sbcf_in #(
    .MAX_SPRITE (MAX_SPRITE)
  ) u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_src_pixel (in_src_pixel),
    .cfg          (cfg),
    .restart      (restart),
    .s1_valid     (s1_valid),
    .s1_ready     (s1_ready),
    .s1           (s1)
  );

  sbcf_px u_px (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .s1        (s1),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign out_write_enable = res.we;
  assign out_fb_address   = res.addr;
  assign out_pixel        = res.pix;
  assign out_sprite_done  = res.done;

endmodule

### verif/sprite_blit_clip_flip_colorkey_top_tb.sv
module sprite_blit_clip_flip_colorkey_top_tb;

  localparam int MAX_SPRITE  = 128;
  localparam int MAX_SCREEN  = 512;
  localparam int ITEM_GOAL   = 600;
  localparam int STALL_LIMIT = 2000;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [sbcf_pkg::PIX_W-1:0]    in_src_pixel = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          out_write_enable;
  logic [sbcf_pkg::ADDR_W-1:0]   out_fb_address;
  logic [sbcf_pkg::PIX_W-1:0]    out_pixel;
  logic                          out_sprite_done;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [sbcf_pkg::PADDR_W-1:0]  paddr = '0;
  logic [sbcf_pkg::PDATA_W-1:0]  pwdata = '0;
  logic [sbcf_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;

  // blitter settings and sprite position as the block should hold them
  logic [sbcf_pkg::SPR_W-1:0]        spr_cols = sbcf_pkg::RST_SPRITE_COLS;
  logic [sbcf_pkg::SPR_W-1:0]        spr_rows = sbcf_pkg::RST_SPRITE_ROWS;
  logic signed [sbcf_pkg::POS_W-1:0] pos_x = '0;
  logic signed [sbcf_pkg::POS_W-1:0] pos_y = '0;
  logic [sbcf_pkg::SCR_W-1:0]        scr_cols = sbcf_pkg::RST_SCREEN_COLS;
  logic [sbcf_pkg::SCR_W-1:0]        scr_rows = sbcf_pkg::RST_SCREEN_ROWS;
  logic [1:0]                        mirror = 2'b00;
  logic                              shown = 1'b1;
  int                                col_cnt = 0;
  int                                row_cnt = 0;

  logic [sbcf_pkg::PIX_W-1:0] pending_pixels [$];
  sbcf_pkg::res_t             predicted_writes [$];
  sbcf_pkg::res_t             head_res;

  int idle_levels [4] = '{0, 10, 25, 50};
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int in_gap = 0;
  int out_gap = 0;
  int stall_cycles = 0;
  int queued = 0;
  int accepted = 0;
  int checked = 0;
  int fb_writes = 0;
  int sprite_ends = 0;
  int cfg_writes = 0;
  int phases = 0;
  int errors = 0;

  sprite_blit_clip_flip_colorkey_top #(
    .MAX_SPRITE(MAX_SPRITE),
    .MAX_SCREEN(MAX_SCREEN)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_src_pixel(in_src_pixel),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_write_enable(out_write_enable),
    .out_fb_address(out_fb_address),
    .out_pixel(out_pixel),
    .out_sprite_done(out_sprite_done),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic int eff_size(input int v);
    return (v == 0) ? 1 : ((v > MAX_SPRITE) ? MAX_SPRITE : v);
  endfunction

  function automatic int eff_screen(input int v);
    return (v > MAX_SCREEN) ? MAX_SCREEN : v;
  endfunction

  // frame buffer write for one source pixel, advancing the raster position
  function automatic sbcf_pkg::res_t blit_pixel(input logic [sbcf_pkg::PIX_W-1:0] p);
    int             cols, rows, scols, srows, c, r, x, y, a;
    bit             last_col;
    sbcf_pkg::res_t res;
    cols  = eff_size(int'(spr_cols));
    rows  = eff_size(int'(spr_rows));
    scols = eff_screen(int'(scr_cols));
    srows = eff_screen(int'(scr_rows));
    c = (col_cnt < cols) ? col_cnt : cols - 1;
    r = (row_cnt < rows) ? row_cnt : rows - 1;
    x = (mirror[0] ? cols - 1 - c : c) + int'(pos_x);
    y = (mirror[1] ? rows - 1 - r : r) + int'(pos_y);
    a = y * scols + x;
    res.we   = (x >= 0) && (y >= 0) && (x < scols) && (y < srows) && shown && p[0];
    res.addr = res.we ? a[sbcf_pkg::ADDR_W-1:0] : '0;
    res.pix  = res.we ? ((p & sbcf_pkg::RG_MASK) | ((p & sbcf_pkg::BLUE_MASK) >> 1)) : '0;
    last_col = (c + 1 >= cols);
    res.done = last_col && (r + 1 >= rows);
    if (last_col) begin
      col_cnt = 0;
      row_cnt = res.done ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
      row_cnt = r;
    end
    return res;
  endfunction

  function automatic int pick_sprite();
    case ($urandom_range(19))
      0: return 0;
      1: return MAX_SPRITE;
      2: return $urandom_range(255, MAX_SPRITE + 1);
      3: return $urandom_range(40, 9);
      default: return $urandom_range(8, 1);
    endcase
  endfunction

  function automatic int pick_screen();
    case ($urandom_range(9))
      0: return 0;
      1: return MAX_SCREEN;
      2: return $urandom_range(1023, MAX_SCREEN + 1);
      3: return 320;
      default: return $urandom_range(24, 1);
    endcase
  endfunction

  function automatic int pick_pos(input int span, input int scr);
    case ($urandom_range(5))
      0: return $urandom_range(1023);
      1: return -512;
      2: return 511;
      default: return int'($urandom_range(scr + span)) - span;
    endcase
  endfunction

  task automatic cfg_write(input sbcf_pkg::reg_idx_t idx,
                           input logic [sbcf_pkg::PDATA_W-1:0] value);
    logic [sbcf_pkg::PDATA_W-1:0] keep;
    case (idx) inside
      sbcf_pkg::REG_SPRITE_COLS, sbcf_pkg::REG_SPRITE_ROWS: keep = 32'hFF;
      sbcf_pkg::REG_POS_X, sbcf_pkg::REG_POS_Y,
      sbcf_pkg::REG_SCREEN_COLS, sbcf_pkg::REG_SCREEN_ROWS: keep = 32'h3FF;
      sbcf_pkg::REG_MIRROR_MODE: keep = 32'h3;
      default: keep = 32'h1;
    endcase
    value = value & keep;
    // unused upper data bits must be ignored
    if ($urandom_range(1)) value = value | ($urandom() & ~keep);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if ((prdata & keep) !== (value & keep)) begin
      $error("register %0d readback: expected %0h, got %0h", idx, value & keep,
             prdata & keep);
      errors++;
    end
    case (idx)
      sbcf_pkg::REG_SPRITE_COLS: begin
        spr_cols = value[sbcf_pkg::SPR_W-1:0];
        col_cnt = 0;
        row_cnt = 0;
      end
      sbcf_pkg::REG_SPRITE_ROWS: begin
        spr_rows = value[sbcf_pkg::SPR_W-1:0];
        col_cnt = 0;
        row_cnt = 0;
      end
      sbcf_pkg::REG_POS_X: pos_x = value[sbcf_pkg::POS_W-1:0];
      sbcf_pkg::REG_POS_Y: pos_y = value[sbcf_pkg::POS_W-1:0];
      sbcf_pkg::REG_SCREEN_COLS: scr_cols = value[sbcf_pkg::SCR_W-1:0];
      sbcf_pkg::REG_SCREEN_ROWS: scr_rows = value[sbcf_pkg::SCR_W-1:0];
      sbcf_pkg::REG_MIRROR_MODE: begin
        mirror = value[1:0];
        col_cnt = 0;
        row_cnt = 0;
      end
      default: shown = value[0];
    endcase
    cfg_writes++;
  endtask

  task automatic random_settings(input bit all_regs);
    int cols, pv;
    if (all_regs || $urandom_range(1)) cfg_write(sbcf_pkg::REG_SCREEN_COLS, pick_screen());
    if (all_regs || $urandom_range(1)) cfg_write(sbcf_pkg::REG_SCREEN_ROWS, pick_screen());
    if (all_regs || $urandom_range(1)) cfg_write(sbcf_pkg::REG_SPRITE_COLS, pick_sprite());
    cols = eff_size(int'(spr_cols));
    if (all_regs || $urandom_range(1) || cols * eff_size(int'(spr_rows)) > 256) begin
      pv = pick_sprite();
      if (cols * eff_size(pv) > 256) pv = $urandom_range(2);
      cfg_write(sbcf_pkg::REG_SPRITE_ROWS, pv);
    end
    if (all_regs || $urandom_range(1))
      cfg_write(sbcf_pkg::REG_MIRROR_MODE, $urandom_range(3));
    if (all_regs || $urandom_range(1))
      cfg_write(sbcf_pkg::REG_SHOWN, 32'($urandom_range(9) != 0));
    if (all_regs || $urandom_range(1))
      cfg_write(sbcf_pkg::REG_POS_X, pick_pos(cols, eff_screen(int'(scr_cols))));
    if (all_regs || $urandom_range(1))
      cfg_write(sbcf_pkg::REG_POS_Y,
                pick_pos(eff_size(int'(spr_rows)), eff_screen(int'(scr_rows))));
  endtask

  task automatic send(input logic [sbcf_pkg::PIX_W-1:0] p);
    pending_pixels.push_back(p);
    queued++;
  endtask

  // wait until the pipeline is empty before touching the registers
  task automatic settle();
    while (pending_pixels.size() != 0 || in_valid || predicted_writes.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_src_pixel <= '0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_writes.push_back(blit_pixel(in_src_pixel));
        accepted++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_gap = in_gap - 1;
          in_valid <= 1'b0;
        end else if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
          in_gap = $urandom_range(7);
          in_valid <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          in_valid     <= 1'b1;
          in_src_pixel <= pending_pixels.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_writes.size() == 0) begin
          $error("result transaction with no pixel outstanding");
          errors++;
        end else begin
          head_res = predicted_writes.pop_front();
          checked++;
          if (head_res.we) fb_writes++;
          if (head_res.done) sprite_ends++;
          if (out_write_enable !== head_res.we) begin
            $error("write_enable: expected %0d, got %0d", head_res.we, out_write_enable);
            errors++;
          end
          if (out_fb_address !== head_res.addr) begin
            $error("fb_address: expected %0h, got %0h", head_res.addr, out_fb_address);
            errors++;
          end
          if (out_pixel !== head_res.pix) begin
            $error("out_pixel: expected %0h, got %0h", head_res.pix, out_pixel);
            errors++;
          end
          if (out_sprite_done !== head_res.done) begin
            $error("sprite_done: expected %0d, got %0d", head_res.done, out_sprite_done);
            errors++;
          end
        end
      end
      if (out_gap != 0) begin
        out_gap = out_gap - 1;
        out_ready <= 1'b0;
      end else if (out_idle_pct != 0 && $urandom_range(99) < out_idle_pct) begin
        out_gap = $urandom_range(7);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $error("no transaction for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [sbcf_pkg::PIX_W-1:0] mix [9];
    logic [sbcf_pkg::PIX_W-1:0] pix;
    logic [31:0]                rnd;
    int                         n;
    mix = '{16'hFFFF, 16'h0001, 16'hF801, 16'h07E1, 16'h003F,
            16'hFFFE, 16'h8421, 16'h5555, 16'hAAAB};
    in_idle_pct  = 25;
    out_idle_pct = 25;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // defaults after reset: 1x1 sprite at the origin
    send(16'hFFFF);
    send(16'h0000);
    send(16'h0001);
    send(16'hFFFE);
    settle();

    // bottom right corner of the largest screen, zero sprite sizes
    cfg_write(sbcf_pkg::REG_SCREEN_COLS, MAX_SCREEN);
    cfg_write(sbcf_pkg::REG_SCREEN_ROWS, MAX_SCREEN);
    cfg_write(sbcf_pkg::REG_SPRITE_COLS, 0);
    cfg_write(sbcf_pkg::REG_SPRITE_ROWS, 0);
    cfg_write(sbcf_pkg::REG_POS_X, 511);
    cfg_write(sbcf_pkg::REG_POS_Y, 511);
    send(16'hFFFF);
    send(16'h003F);
    settle();

    // 3x3 sprite mirrored both ways, clipped on the left and the bottom
    cfg_write(sbcf_pkg::REG_SPRITE_COLS, 3);
    cfg_write(sbcf_pkg::REG_SPRITE_ROWS, 3);
    cfg_write(sbcf_pkg::REG_POS_X, -1);
    cfg_write(sbcf_pkg::REG_POS_Y, 1);
    cfg_write(sbcf_pkg::REG_SCREEN_COLS, 3);
    cfg_write(sbcf_pkg::REG_SCREEN_ROWS, 3);
    cfg_write(sbcf_pkg::REG_MIRROR_MODE, 3);
    cfg_write(sbcf_pkg::REG_SHOWN, 1);
    foreach (mix[i]) send(mix[i]);
    settle();

    // hidden sprite, left partway through
    cfg_write(sbcf_pkg::REG_SHOWN, 0);
    cfg_write(sbcf_pkg::REG_MIRROR_MODE, 1);
    send(16'hFFFF);
    send(16'h0001);
    send(16'hF83F);
    settle();

    // zero screen width, then an oversized screen
    cfg_write(sbcf_pkg::REG_SHOWN, 1);
    cfg_write(sbcf_pkg::REG_SCREEN_COLS, 0);
    send(16'hFFFF);
    settle();
    cfg_write(sbcf_pkg::REG_SCREEN_COLS, 1000);
    cfg_write(sbcf_pkg::REG_SCREEN_ROWS, 1023);
    send(16'hFFFF);
    settle();

    while (queued < ITEM_GOAL) begin
      random_settings(phases == 0);
      n = eff_size(int'(spr_cols)) * eff_size(int'(spr_rows)) * ($urandom_range(1) + 1)
          + $urandom_range(3);
      if (n > 300) n = 300;
      if (n > ITEM_GOAL + 20 - queued) n = ITEM_GOAL + 20 - queued;
      if (queued + n >= ITEM_GOAL - 120) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = idle_levels[$urandom_range(3)];
        out_idle_pct = idle_levels[$urandom_range(3)];
      end
      repeat (n) begin
        rnd = $urandom_range(16'hFFFF);
        pix = rnd[sbcf_pkg::PIX_W-1:0];
        if ($urandom_range(3) != 0) pix[0] = 1'b1;
        send(pix);
      end
      phases++;
      settle();
    end

    $display("%0d pixels over %0d random settings phases, %0d register writes",
             accepted, phases, cfg_writes);
    $display("%0d results checked: %0d frame buffer writes, %0d sprite ends",
             checked, fb_writes, sprite_ends);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
